/* design/integer_to_base_n_ascii_unit_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the integer to base-N ASCII unit
// Clocked, reset-gated property wrappers used by the checker module.
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_BASE_N_ASCII_UNIT_MACROS_SVH
`define INTEGER_TO_BASE_N_ASCII_UNIT_MACROS_SVH

// same-cycle implication
`define IBN_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IBN_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ibn_pkg.sv */
// ---------------------------------------------------------------------------
// ibn_pkg
// Widths, constants and helpers of the integer to base-N ASCII unit.
// ---------------------------------------------------------------------------
`default_nettype none

package ibn_pkg;

  localparam int unsigned RADIX_W = 6;
  localparam int unsigned DIGIT_W = 6;
  localparam int unsigned CHAR_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;  // '0'
  localparam logic [CHAR_W-1:0] ASCII_NINE = 7'h39;  // '9'
  localparam logic [CHAR_W-1:0] ASCII_A    = 7'h41;  // 'A'
  localparam logic [CHAR_W-1:0] ASCII_Z    = 7'h5A;  // 'Z'
  localparam logic [DIGIT_W-1:0] DEC_TEN   = 6'd10;

  // bases outside 2..36 are clamped to the nearest end
  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end else begin
      res = r;
    end
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < DEC_TEN) begin
      res = ASCII_ZERO + {1'b0, d};
    end else begin
      res = ASCII_A + {1'b0, d - DEC_TEN};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* design/integer_to_base_n_ascii_unit.sv */
// ---------------------------------------------------------------------------
// integer_to_base_n_ascii_unit
// Converts an unsigned integer to ASCII digits in a configurable base.
// ---------------------------------------------------------------------------
//   channel   handshake                 payload
//   in        in_valid_i / in_ready_o   value_i
//   out       out_valid_o / out_ready_i digit_char_o, last_digit_o
//   cfg       cfg_we_i                  cfg_wdata_i (radix)
//
// Each digit comes from the bit-serial divider, then each character passes
// through the registered digit store read port (S_FETCH, then S_EMIT); a
// result has at most 31 digits with the default widths (base 2).
// One transaction is in flight at a time; a new one is taken while the final
// character still waits in the output register. Output stalls hold the emit
// loop. Reset sets radix to 10; the digit store is not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module integer_to_base_n_ascii_unit
  import ibn_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 32,
  parameter int unsigned VALUE_BITS = 31
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [RADIX_W-1:0]    cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [VALUE_BITS-1:0] value_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [CHAR_W-1:0]          digit_char_o,
  output logic                       last_digit_o
);

  localparam int unsigned IDX_W = $clog2(MAX_DIGITS);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DIV   = 2'd1;
  localparam logic [1:0] S_FETCH = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [RADIX_W-1:0] radix_q;
  logic [RADIX_W-1:0] base_q, base_d;
  logic [IDX_W-1:0]   cnt_q, cnt_d;
  logic [IDX_W-1:0]   rd_ptr_q, rd_ptr_d;

  logic                  out_valid_q;
  logic [CHAR_W-1:0]     char_q;
  logic                  last_q;

  logic [DIGIT_W-1:0] digit_store_q [MAX_DIGITS];
  logic [DIGIT_W-1:0] rd_data_q;

  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quo;
  logic [DIGIT_W-1:0]    div_rem;
  logic                  wr_en;
  logic                  load_out;

  ibn_div #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (base_q),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_comb begin
    state_d      = state_q;
    base_d       = base_q;
    cnt_d        = cnt_q;
    rd_ptr_d     = rd_ptr_q;
    div_start    = 1'b0;
    div_dividend = value_i;
    wr_en        = 1'b0;
    load_out     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          base_d    = eff_radix(radix_q);
          cnt_d     = '0;
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          wr_en = 1'b1;
          // stop on a zero quotient or a full store
          if (div_quo == '0 || cnt_q == IDX_W'(MAX_DIGITS - 1)) begin
            rd_ptr_d = cnt_q;
            state_d  = S_FETCH;
          end else begin
            cnt_d        = cnt_q + IDX_W'(1);
            div_start    = 1'b1;
            div_dividend = div_quo;
          end
        end
      end
      S_FETCH: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          if (rd_ptr_q == '0) begin
            state_d = S_IDLE;
          end else begin
            rd_ptr_d = rd_ptr_q - IDX_W'(1);
            state_d  = S_FETCH;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      radix_q     <= RADIX_RESET;
      base_q      <= RADIX_RESET;
      cnt_q       <= '0;
      rd_ptr_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      base_q   <= base_d;
      cnt_q    <= cnt_d;
      rd_ptr_q <= rd_ptr_d;
      if (cfg_we_i) begin
        radix_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      char_q <= digit_to_ascii(rd_data_q);
      last_q <= (rd_ptr_q == '0);
    end
  end

  // digit store, least significant digit at entry 0
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      digit_store_q[cnt_q] <= div_rem;
    end
    rd_data_q <= digit_store_q[rd_ptr_q];
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign digit_char_o = char_q;
  assign last_digit_o = last_q;

endmodule

`default_nettype wire

/* design/ibn_div.sv */
// ---------------------------------------------------------------------------
// ibn_div
// Bit-serial restoring divider: one quotient bit per cycle, small divisor.
// ---------------------------------------------------------------------------
`default_nettype none

module ibn_div
  import ibn_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 31
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [VALUE_BITS-1:0] dividend_i,
  input  wire logic [RADIX_W-1:0]    divisor_i,
  output logic                       done_o,
  output logic [VALUE_BITS-1:0]      quotient_o,
  output logic [DIGIT_W-1:0]         remainder_o
);

  localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] quo_q, quo_d;
  logic [DIGIT_W-1:0]    rem_q, rem_d;

  logic [DIGIT_W:0] trial;
  logic [DIGIT_W:0] diff;
  logic             fits;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem_q, quo_q[VALUE_BITS-1]};
  assign fits  = trial >= {1'b0, divisor_i};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(VALUE_BITS);
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quo_d = {quo_q[VALUE_BITS-2:0], fits};
      rem_d = fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

/* design/ibn_checker.sv */
// ---------------------------------------------------------------------------
// ibn_checker
// Port-level checks of the integer to base-N ASCII unit, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

`include "integer_to_base_n_ascii_unit_macros.svh"

module ibn_checker
  import ibn_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic [CHAR_W-1:0] digit_char_o,
  input wire logic              last_digit_o
);

  // a stalled character holds
  `IBN_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(digit_char_o) && $stable(last_digit_o), "output changed while stalled")

  // only legal digit characters appear
  `IBN_ASSERT_IMP(a_char_legal, clk_i, rst_ni, out_valid_o, (digit_char_o >= ASCII_ZERO && digit_char_o <= ASCII_NINE) || (digit_char_o >= ASCII_A && digit_char_o <= ASCII_Z), "illegal digit character")

  // one transaction at a time: input side closes after a transaction
  `IBN_ASSERT_NXT(a_busy_after_in, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "input ready right after a transaction")

  // the input side cannot reopen before the final character is loaded
  `IBN_ASSERT_NXT(a_ready_needs_last, clk_i, rst_ni, !in_ready_o && !out_valid_o, !in_ready_o || (out_valid_o && last_digit_o), "input reopened without a final character")

endmodule

bind integer_to_base_n_ascii_unit ibn_checker u_ibn_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .digit_char_o (digit_char_o),
  .last_digit_o (last_digit_o)
);

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: integer to base-N ASCII unit testbench
// Sends integers in several bases, predicts the ASCII digit stream of each
// conversion and checks each character and its last flag in order; the value
// and character channels idle at random in all but the full-rate phase.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ibn_pkg::*;

  localparam int unsigned VALUE_W      = 31;
  localparam int unsigned DIGITS_MAX   = 32;
  localparam int unsigned CYCLE_LIMIT  = 3000000;
  localparam int unsigned DRAIN_CYCLES = 128;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned ITEMS_PHASE  = 48;
  localparam int unsigned ITEMS_RADIX  = 9;

  localparam logic [VALUE_W-1:0] VALUE_ALL_ONES = '1;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;
  } ascii_char_t;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_we_i     = 1'b0;
  logic [RADIX_W-1:0]   cfg_wdata_i  = '0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_ready_o;
  logic [VALUE_W-1:0]   value_i      = '0;
  logic                 out_valid_o;
  logic                 out_ready_i  = 1'b0;
  logic [CHAR_W-1:0]    digit_char_o;
  logic                 last_digit_o;

  ascii_char_t          expected_chars[$];
  logic [RADIX_W-1:0]   radix_reg;
  int unsigned          send_idle_pct;
  int unsigned          recv_idle_pct;
  int unsigned          error_count;
  int unsigned          cycle_count;

  integer_to_base_n_ascii_unit #(
    .MAX_DIGITS (DIGITS_MAX),
    .VALUE_BITS (VALUE_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digit_char_o (digit_char_o),
    .last_digit_o (last_digit_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---- prediction ----------------------------------------------------------

  function automatic int unsigned effective_base();
    int unsigned base;
    if (radix_reg < RADIX_MIN) begin
      base = 32'(RADIX_MIN);
    end else if (radix_reg > RADIX_MAX) begin
      base = 32'(RADIX_MAX);
    end else begin
      base = 32'(radix_reg);
    end
    return base;
  endfunction

  // digits come out of the divider LSB first, go on the wire MSB first
  function automatic void push_expected_digits(input logic [VALUE_W-1:0] v);
    logic [DIGIT_W-1:0] digits[DIGITS_MAX];
    logic [VALUE_W-1:0] quot;
    int unsigned        base;
    int unsigned        n;
    int unsigned        k;
    ascii_char_t        c;
    base = effective_base();
    quot = v;
    n    = 0;
    if (quot == '0) begin
      digits[0] = '0;
      n = 1;
    end else begin
      while (quot != '0 && n < DIGITS_MAX) begin
        digits[n] = DIGIT_W'(quot % base);
        quot      = VALUE_W'(quot / base);
        n++;
      end
    end
    for (k = n; k > 0; k--) begin
      if (digits[k-1] < DEC_TEN) begin
        c.digit_char = ASCII_ZERO + CHAR_W'(digits[k-1]);
      end else begin
        c.digit_char = ASCII_A + CHAR_W'(digits[k-1] - DEC_TEN);
      end
      c.last_digit = (k == 1);
      expected_chars.push_back(c);
    end
  endfunction

  // ---- character checker ---------------------------------------------------

  always @(posedge clk_i) begin
    ascii_char_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_chars.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("unexpected character %h last %b", digit_char_o, last_digit_o);
        end
      end else begin
        want = expected_chars.pop_front();
        if (digit_char_o !== want.digit_char || last_digit_o !== want.last_digit) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("mismatch: char exp %h got %h, last exp %b got %b",
                     want.digit_char, digit_char_o, want.last_digit, last_digit_o);
          end
        end
      end
    end
  end

  // ---- drivers -------------------------------------------------------------

  // valid is left high on return so back-to-back transactions need no gap
  task automatic send_value(input logic [VALUE_W-1:0] v);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
    push_expected_digits(v);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_chars.size() != 0);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] r);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= r;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    radix_reg   = r;
  endtask

  // ---- stimulus helpers ----------------------------------------------------

  // base^k or base^k - 1: values right at a digit count change
  function automatic logic [VALUE_W-1:0] digit_count_edge();
    longint unsigned p;
    int unsigned     base;
    int unsigned     k;
    base = effective_base();
    p    = 1;
    k    = $urandom_range(1, 31);
    repeat (k) begin
      if (p * base <= longint'(VALUE_ALL_ONES)) p = p * base;
    end
    if ($urandom_range(1) == 1) p = p - 1;
    return VALUE_W'(p);
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(9))
      0:       v = '0;
      1:       v = VALUE_ALL_ONES;
      2, 3:    v = VALUE_W'($urandom_range(255));
      4, 5:    v = digit_count_edge();
      default: v = VALUE_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [RADIX_W-1:0] random_radix();
    logic [RADIX_W-1:0] r;
    case ($urandom_range(7))
      0:       r = RADIX_W'($urandom_range(63));  // may hit the clamped codes
      1:       r = ($urandom_range(1) == 1) ? RADIX_MIN : RADIX_MAX;
      default: r = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
    endcase
    return r;
  endfunction

  task automatic run_random_items(input int unsigned count);
    int unsigned i;
    for (i = 0; i < count; i++) begin
      if (i % ITEMS_RADIX == 0) begin
        wait_drained();
        write_radix(random_radix());
      end
      send_value(random_value());
    end
    wait_drained();
  endtask

  // ---- tests ---------------------------------------------------------------

  task automatic test_reset_base();
    send_value('0);
    send_value(VALUE_W'(7));
    send_value(VALUE_W'(10));
    send_value(VALUE_W'(1234567890));
    send_value(VALUE_ALL_ONES);
    wait_drained();
  endtask

  task automatic test_base_extremes();
    write_radix(RADIX_MIN);
    send_value('0);
    send_value(VALUE_W'(1));
    send_value(VALUE_ALL_ONES);       // longest digit string
    send_value(VALUE_W'(32'h5555_5555));
    wait_drained();
    write_radix(RADIX_MAX);
    send_value(VALUE_W'(35));
    send_value(VALUE_W'(36));
    send_value(VALUE_W'(60466175));   // ZZZZZ
    send_value(VALUE_ALL_ONES);
    wait_drained();
    write_radix(RADIX_W'(16));
    send_value(VALUE_W'(32'h2ABC_DEF9));
    wait_drained();
  endtask

  task automatic test_base_clamp();
    write_radix(RADIX_W'(0));
    send_value(VALUE_ALL_ONES);
    wait_drained();
    write_radix(RADIX_W'(1));
    send_value(VALUE_W'(6));
    wait_drained();
    write_radix(RADIX_W'(37));
    send_value(VALUE_W'(1295));
    wait_drained();
    write_radix(RADIX_W'(63));
    send_value(VALUE_ALL_ONES);
    send_value('0);
    wait_drained();
  endtask

  task automatic test_random_slow_sink();
    send_idle_pct = 8;
    recv_idle_pct = 68;
    run_random_items(ITEMS_PHASE);
  endtask

  task automatic test_random_slow_source();
    send_idle_pct = 68;
    recv_idle_pct = 8;
    run_random_items(ITEMS_PHASE);
  endtask

  task automatic test_random_full_rate();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_items(ITEMS_PHASE);
  endtask

  initial begin
    radix_reg     = RADIX_RESET;
    send_idle_pct = 8;
    recv_idle_pct = 68;
    error_count   = 0;
    cycle_count   = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_base();
    test_base_extremes();
    test_base_clamp();
    test_random_slow_sink();
    test_random_slow_source();
    test_random_full_rate();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && expected_chars.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
+incdir+design
design/ibn_pkg.sv
design/ibn_div.sv
design/integer_to_base_n_ascii_unit.sv
design/ibn_checker.sv
tb/tb_top.sv
